@@ src/pms_pkg.sv @@
`default_nettype none
package pms_pkg;

    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned MsW       = 8;
    localparam int unsigned CodeW     = 4;
    localparam int unsigned FastElW   = 17;
    localparam int unsigned LongElW   = 18;
    localparam int unsigned MaxRes    = 3;

    typedef logic [CodeW-1:0] t_code;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_FAST_INTERVAL   = 3'd0,
        REG_SECOND_INTERVAL = 3'd1,
        REG_SLOW_INTERVAL   = 3'd2,
        REG_SECOND_PHASE    = 3'd3,
        REG_SLOW_PHASE      = 3'd4,
        REG_SCHEDULE_MODE   = 3'd5
    } t_reg_idx;

    localparam logic [CfgDataW-1:0] RstFastInterval   = 16'd416;
    localparam logic [CfgDataW-1:0] RstSecondInterval = 16'd500;
    localparam logic [CfgDataW-1:0] RstSlowInterval   = 16'd20000;
    localparam logic [CfgDataW-1:0] RstSecondPhase    = 16'd300;
    localparam logic [CfgDataW-1:0] RstSlowPhase      = 16'd200;

    // message codes
    localparam t_code MsgTimers        = 4'd0;
    localparam t_code MsgScheduleNight = 4'd6;
    localparam t_code MsgScheduleDay   = 4'd7;
    localparam t_code MsgDiagnostic    = 4'd12;
    localparam t_code MsgHeaterInfo    = 4'd13;
    localparam t_code MsgHcuInfo       = 4'd15;

    localparam logic [3:0] FastLastSlot = 4'd11;
    localparam logic [1:0] SlowLastSlot = 2'd2;

    typedef struct packed {
        logic [CfgDataW-1:0] fast_interval;
        logic [CfgDataW-1:0] second_interval;
        logic [CfgDataW-1:0] slow_interval;
        logic [CfgDataW-1:0] second_phase;
        logic [CfgDataW-1:0] slow_phase;
        logic                schedule_mode;
    } t_cfg;

    // results of one item, packed in order from entry 0
    typedef struct packed {
        logic [1:0]             count;
        t_code [MaxRes-1:0]     codes;
    } t_bundle;

endpackage
`default_nettype wire

@@ src/pms_if.sv @@
`default_nettype none
interface pms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ms_elapsed;

    modport source (output valid, output ms_elapsed, input ready);
    modport sink (input valid, input ms_elapsed, output ready);
endinterface

interface pms_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] message_code;
    logic       last;

    modport source (output valid, output message_code, output last, input ready);
    modport sink (input valid, input message_code, input last, output ready);
endinterface

interface pms_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/pms_cfg_regs.sv @@
`default_nettype none
module pms_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [pms_pkg::CfgIdxW-1:0]   i_idx,
    input  wire logic [pms_pkg::CfgDataW-1:0]  i_data,
    output pms_pkg::t_cfg                      o_cfg
);
    import pms_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_interval   <= RstFastInterval;
            r_cfg.second_interval <= RstSecondInterval;
            r_cfg.slow_interval   <= RstSlowInterval;
            r_cfg.second_phase    <= RstSecondPhase;
            r_cfg.slow_phase      <= RstSlowPhase;
            r_cfg.schedule_mode   <= 1'b0;
        end else if (i_wr) begin
            case (i_idx)
                REG_FAST_INTERVAL:   r_cfg.fast_interval   <= i_data;
                REG_SECOND_INTERVAL: r_cfg.second_interval <= i_data;
                REG_SLOW_INTERVAL:   r_cfg.slow_interval   <= i_data;
                REG_SECOND_PHASE:    r_cfg.second_phase    <= i_data;
                REG_SLOW_PHASE:      r_cfg.slow_phase      <= i_data;
                REG_SCHEDULE_MODE:   r_cfg.schedule_mode   <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ src/pms_timers.sv @@
`default_nettype none
module pms_timers (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [pms_pkg::MsW-1:0]   i_ms,
    input  wire pms_pkg::t_cfg             i_cfg,
    output pms_pkg::t_bundle               o_bundle
);
    import pms_pkg::*;

    logic [FastElW-1:0] r_fast_el,   n_fast_el;
    logic [LongElW-1:0] r_second_el, n_second_el;
    logic [LongElW-1:0] r_slow_el,   n_slow_el;
    logic               r_second_started, n_second_started;
    logic               r_slow_started,   n_slow_started;
    logic [3:0]         r_fast_slot,   n_fast_slot;
    logic               r_second_slot, n_second_slot;
    logic [1:0]         r_slow_slot,   n_slow_slot;

    logic [FastElW:0]   fast_sum;
    logic [LongElW:0]   second_sum, slow_sum;
    logic [FastElW-1:0] fast_sat;
    logic [LongElW-1:0] second_sat, slow_sat;
    logic [CfgDataW:0]  second_thr, slow_thr;
    logic               second_fire, fast_fire, slow_fire;
    logic               second_emit, fast_emit;
    t_code              fast_code, slow_code;
    t_bundle            bundle;

    always_comb begin
        second_sum = {1'b0, r_second_el} + (LongElW+1)'(i_ms);
        fast_sum   = {1'b0, r_fast_el} + (FastElW+1)'(i_ms);
        slow_sum   = {1'b0, r_slow_el} + (LongElW+1)'(i_ms);
        second_sat = second_sum[LongElW] ? '1 : second_sum[LongElW-1:0];
        fast_sat   = fast_sum[FastElW] ? '1 : fast_sum[FastElW-1:0];
        slow_sat   = slow_sum[LongElW] ? '1 : slow_sum[LongElW-1:0];

        // phase delay counts only until the first firing
        second_thr = {1'b0, i_cfg.second_interval}
                   + (r_second_started ? '0 : {1'b0, i_cfg.second_phase});
        slow_thr   = {1'b0, i_cfg.slow_interval}
                   + (r_slow_started ? '0 : {1'b0, i_cfg.slow_phase});

        second_fire = second_sat >= LongElW'(second_thr);
        fast_fire   = fast_sat >= FastElW'(i_cfg.fast_interval);
        slow_fire   = slow_sat >= LongElW'(slow_thr);

        second_emit = second_fire && !r_second_slot;

        if (r_fast_slot >= FastLastSlot) begin
            fast_code = MsgDiagnostic;
        end else begin
            fast_code = r_fast_slot + 4'd1;
        end
        fast_emit = fast_fire
                  && (i_cfg.schedule_mode
                      || (fast_code != MsgScheduleNight && fast_code != MsgScheduleDay));

        if (r_slow_slot >= SlowLastSlot) begin
            slow_code = MsgHcuInfo;
        end else begin
            slow_code = MsgHeaterInfo + {2'b00, r_slow_slot};
        end
    end

    // compact the codes in order second, fast, slow
    always_comb begin
        bundle = '0;
        if (second_emit) begin
            bundle.codes[0] = MsgTimers;
            bundle.count    = 2'd1;
        end
        if (fast_emit) begin
            bundle.codes[bundle.count] = fast_code;
            bundle.count               = bundle.count + 2'd1;
        end
        if (slow_fire) begin
            bundle.codes[bundle.count] = slow_code;
            bundle.count               = bundle.count + 2'd1;
        end
    end

    always_comb begin
        n_second_el      = second_fire ? '0 : second_sat;
        n_fast_el        = fast_fire ? '0 : fast_sat;
        n_slow_el        = slow_fire ? '0 : slow_sat;
        n_second_started = r_second_started | second_fire;
        n_slow_started   = r_slow_started | slow_fire;
        n_second_slot    = r_second_slot ^ second_fire;
        n_fast_slot      = r_fast_slot;
        n_slow_slot      = r_slow_slot;
        if (fast_fire) begin
            n_fast_slot = (r_fast_slot >= FastLastSlot) ? 4'd0 : r_fast_slot + 4'd1;
        end
        if (slow_fire) begin
            n_slow_slot = (r_slow_slot >= SlowLastSlot) ? 2'd0 : r_slow_slot + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_el        <= '0;
            r_second_el      <= '0;
            r_slow_el        <= '0;
            r_second_started <= 1'b0;
            r_slow_started   <= 1'b0;
            r_fast_slot      <= '0;
            r_second_slot    <= 1'b0;
            r_slow_slot      <= '0;
        end else if (i_accept) begin
            r_fast_el        <= n_fast_el;
            r_second_el      <= n_second_el;
            r_slow_el        <= n_slow_el;
            r_second_started <= n_second_started;
            r_slow_started   <= n_slow_started;
            r_fast_slot      <= n_fast_slot;
            r_second_slot    <= n_second_slot;
            r_slow_slot      <= n_slow_slot;
        end
    end

    assign o_bundle = bundle;

endmodule
`default_nettype wire

@@ src/pms_res_queue.sv @@
`default_nettype none
module pms_res_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire pms_pkg::t_bundle    i_bundle,
    output logic                     o_full,
    output logic                     o_valid,
    output pms_pkg::t_code           o_code,
    output logic                     o_last,
    input  wire logic                i_ready
);
    import pms_pkg::*;

    t_bundle    r_fifo [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] r_sel;
    logic       r_o_valid;
    t_code      r_o_code;
    logic       r_o_last;

    t_bundle    head;
    logic       out_free;
    logic       move;
    logic       head_last;
    logic       pop;

    always_comb begin
        head      = r_fifo[r_rptr];
        out_free  = !r_o_valid || i_ready;
        move      = out_free && (r_cnt != 2'd0);
        head_last = r_sel == (head.count - 2'd1);
        pop       = move && head_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fifo[r_wptr] <= i_bundle;
        end
        if (move) begin
            r_o_code <= head.codes[r_sel];
            r_o_last <= head_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= 1'b0;
            r_rptr    <= 1'b0;
            r_cnt     <= '0;
            r_sel     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
                r_sel  <= '0;
            end else if (move) begin
                r_sel  <= r_sel + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
            if (out_free) begin
                r_o_valid <= move;
            end
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_o_valid;
    assign o_code  = r_o_code;
    assign o_last  = r_o_last;

endmodule
`default_nettype wire

@@ src/periodic_message_scheduler_unit.sv @@
`default_nettype none
// Path: a taken item's results go into the two-entry result queue, then one by one into
// the output register, one per cycle while the sink keeps up; the queue depth sets how
// far input runs ahead of output. Throughput: one item per cycle while the queue is not
// full; each result holds the output register until the sink takes it.
// Reset (synchronous, active low): timers, slot pointers and queue clear, registers load
// their default intervals and phases; the block is ready in the cycle after reset.
module periodic_message_scheduler_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pms_cfg_if.sink    i_cfg_ch,
    pms_in_if.sink     i_in_ch,
    pms_out_if.source  o_out_ch
);
    import pms_pkg::*;

    t_cfg    cfg;
    t_bundle bundle;
    logic    in_accept;
    logic    q_full;
    logic    push;

    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = !q_full;
    assign in_accept      = i_in_ch.valid && !q_full;
    // drop items that cause no message
    assign push           = in_accept && (bundle.count != 2'd0);

    pms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_ch.valid),
        .i_idx   (i_cfg_ch.index),
        .i_data  (i_cfg_ch.data),
        .o_cfg   (cfg)
    );

    pms_timers u_timers (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_ms     (i_in_ch.ms_elapsed),
        .i_cfg    (cfg),
        .o_bundle (bundle)
    );

    pms_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_full   (q_full),
        .o_valid  (o_out_ch.valid),
        .o_code   (o_out_ch.message_code),
        .o_last   (o_out_ch.last),
        .i_ready  (o_out_ch.ready)
    );

endmodule
`default_nettype wire

@@ tb/periodic_message_scheduler_unit_test.sv @@
`timescale 1ns / 100ps

module periodic_message_scheduler_unit_test;
    import pms_pkg::*;

    typedef struct packed {
        t_code code;
        logic  last;
    } t_sched_msg;

    logic i_clk;
    logic i_rst_n;

    pms_cfg_if cfg_ch ();
    pms_in_if  in_ch ();
    pms_out_if out_ch ();

    periodic_message_scheduler_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (cfg_ch),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // timer model state
    t_cfg               cur_cfg;
    logic [FastElW-1:0] fast_ms;
    logic [LongElW-1:0] second_ms;
    logic [LongElW-1:0] slow_ms;
    logic               second_run;
    logic               slow_run;
    logic [3:0]         fast_ptr;
    logic               second_ptr;
    logic [1:0]         slow_ptr;

    t_sched_msg  pending_msgs[$];
    int unsigned idle_max;
    int unsigned mismatches;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Work out the messages one item causes and queue them in bus order.
    function automatic void advance_timers(input logic [MsW-1:0] ms);
        t_code       fired[$];
        t_code       code;
        logic [31:0] sum;
        logic [31:0] thr;

        sum = second_ms + ms;
        second_ms = (sum >> LongElW) != 0 ? '1 : sum[LongElW-1:0];
        thr = cur_cfg.second_interval + (second_run ? 16'd0 : cur_cfg.second_phase);
        if (second_ms >= thr) begin
            second_ms = '0;
            second_run = 1'b1;
            if (!second_ptr)
                fired.push_back(MsgTimers);
            second_ptr = ~second_ptr;
        end

        sum = fast_ms + ms;
        fast_ms = (sum >> FastElW) != 0 ? '1 : sum[FastElW-1:0];
        if (fast_ms >= cur_cfg.fast_interval) begin
            fast_ms = '0;
            if (fast_ptr >= FastLastSlot) begin
                fired.push_back(MsgDiagnostic);
                fast_ptr = '0;
            end else begin
                code = t_code'(fast_ptr + 4'd1);
                // schedule slots advance silently unless schedule mode is on
                if ((code != MsgScheduleNight && code != MsgScheduleDay) ||
                        cur_cfg.schedule_mode)
                    fired.push_back(code);
                fast_ptr = fast_ptr + 4'd1;
            end
        end

        sum = slow_ms + ms;
        slow_ms = (sum >> LongElW) != 0 ? '1 : sum[LongElW-1:0];
        thr = cur_cfg.slow_interval + (slow_run ? 16'd0 : cur_cfg.slow_phase);
        if (slow_ms >= thr) begin
            slow_ms = '0;
            slow_run = 1'b1;
            if (slow_ptr >= SlowLastSlot) begin
                fired.push_back(MsgHcuInfo);
                slow_ptr = '0;
            end else begin
                fired.push_back(t_code'(MsgHeaterInfo + slow_ptr));
                slow_ptr = slow_ptr + 2'd1;
            end
        end

        foreach (fired[k])
            pending_msgs.push_back('{fired[k], k == fired.size() - 1});
    endfunction

    function automatic t_cfg random_cfg(input int unsigned hi);
        t_cfg c;

        c.fast_interval   = CfgDataW'($urandom_range(hi, 1));
        c.second_interval = CfgDataW'($urandom_range(hi, 1));
        c.slow_interval   = CfgDataW'($urandom_range(hi, 1));
        c.second_phase    = CfgDataW'($urandom_range(hi, 0));
        c.slow_phase      = CfgDataW'($urandom_range(hi, 0));
        c.schedule_mode   = 1'($urandom_range(1, 0));
        return c;
    endfunction

    // Write every register in index order, holding valid across the burst.
    task automatic apply_settings(input t_cfg c);
        int                  i;
        logic [CfgDataW-1:0] value;

        for (i = REG_FAST_INTERVAL; i <= REG_SCHEDULE_MODE; i++) begin
            case (t_reg_idx'(i))
                REG_FAST_INTERVAL:   value = c.fast_interval;
                REG_SECOND_INTERVAL: value = c.second_interval;
                REG_SLOW_INTERVAL:   value = c.slow_interval;
                REG_SECOND_PHASE:    value = c.second_phase;
                REG_SLOW_PHASE:      value = c.slow_phase;
                REG_SCHEDULE_MODE:   value = CfgDataW'(c.schedule_mode);
                default:             value = '0;
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_reg_idx'(i);
            cfg_ch.data  <= value;
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        end
        cfg_ch.valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Valid stays high after acceptance, so back-to-back items see no gap in valid.
    task automatic send_ms(input logic [MsW-1:0] ms);
        int unsigned gap;

        gap = $urandom_range(idle_max, 0);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.ms_elapsed <= ms;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        advance_timers(ms);
    endtask

    // Drain all outstanding messages, then allow for items still in the pipeline.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_random(input t_cfg c, input int unsigned n_items);
        int unsigned i;

        apply_settings(c);
        for (i = 0; i < n_items; i++) begin
            // alternate stretches of heavy idling with none at all
            if (i % 16 == 0)
                idle_max = ($urandom_range(3, 0) == 0) ? 0 : 5;
            send_ms(MsW'($urandom_range(255, 1)));
        end
        settle();
    endtask

    task automatic test_reset_defaults();
        idle_max = 5;
        repeat (4) send_ms(8'hFF);
        settle();
    endtask

    // Zero intervals fire every item, zero elapsed still fires, a phase written after
    // the first firing is ignored and the pending slow phase holds off its first slot.
    task automatic test_zero_and_phase();
        t_cfg c;

        c.fast_interval   = 16'd0;
        c.second_interval = 16'd0;
        c.slow_interval   = 16'd1020;
        c.second_phase    = 16'hFFFF;
        c.slow_phase      = 16'd5;
        c.schedule_mode   = 1'b0;
        apply_settings(c);
        send_ms(8'd0);
        send_ms(8'd0);
        repeat (5) send_ms(8'd1);
        send_ms(8'd0);
        settle();
    endtask

    task automatic test_fast_round_robin();
        t_cfg c;

        c.fast_interval   = 16'd1;
        c.second_interval = 16'hFFFF;
        c.slow_interval   = 16'hFFFF;
        c.second_phase    = 16'd0;
        c.slow_phase      = 16'd0;
        c.schedule_mode   = 1'b1;
        apply_settings(c);
        idle_max = 0;
        repeat (12) send_ms(8'd1);
        settle();
    endtask

    task automatic test_random_short_intervals();
        run_random(random_cfg(300), 70);
    endtask

    task automatic test_random_tight_intervals();
        run_random(random_cfg(40), 50);
    endtask

    task automatic test_random_extreme_intervals();
        t_cfg c;

        c.fast_interval   = 16'hFFFF;
        c.second_interval = 16'd1;
        c.slow_interval   = 16'hFFFF;
        c.second_phase    = 16'hFFFF;
        c.slow_phase      = 16'hFFFF;
        c.schedule_mode   = 1'b1;
        run_random(c, 30);
    endtask

    task automatic test_random_wide_intervals();
        run_random(random_cfg(1500), 60);
    endtask

    // Result sink: random back-pressure, each message checked against the oldest prediction.
    initial begin
        int unsigned stall;
        t_sched_msg  exp_msg;

        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(idle_max, 0);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (pending_msgs.size() == 0) begin
                $display("%0t: unexpected message, code %0d last %0b", $time,
                         out_ch.message_code, out_ch.last);
                mismatches++;
            end else begin
                exp_msg = pending_msgs.pop_front();
                if (out_ch.message_code !== exp_msg.code) begin
                    $display("%0t: message code expected %0d, got %0d", $time,
                             exp_msg.code, out_ch.message_code);
                    mismatches++;
                end
                if (out_ch.last !== exp_msg.last) begin
                    $display("%0t: last flag expected %0b, got %0b", $time,
                             exp_msg.last, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        idle_max   = 5;
        cur_cfg    = '{RstFastInterval, RstSecondInterval, RstSlowInterval,
                       RstSecondPhase, RstSlowPhase, 1'b0};
        fast_ms    = '0;
        second_ms  = '0;
        slow_ms    = '0;
        second_run = 1'b0;
        slow_run   = 1'b0;
        fast_ptr   = '0;
        second_ptr = 1'b0;
        slow_ptr   = '0;

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.ms_elapsed <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_FAST_INTERVAL;
        cfg_ch.data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_and_phase();
        test_fast_round_robin();
        test_random_short_intervals();
        test_random_tight_intervals();
        test_random_extreme_intervals();
        test_random_wide_intervals();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
src/pms_pkg.sv
src/pms_if.sv
src/pms_cfg_regs.sv
src/pms_timers.sv
src/pms_res_queue.sv
src/periodic_message_scheduler_unit.sv
tb/periodic_message_scheduler_unit_test.sv
